>>> rtl/pid_deadband_clamped_top_defines.svh
// Assertion macros for the PID controller with dead zone.
`ifndef PID_DEADBAND_CLAMPED_TOP_DEFINES_SVH
`define PID_DEADBAND_CLAMPED_TOP_DEFINES_SVH

// Checks the consequence in the same cycle as the antecedent.
`define PIDDZ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks the consequence in the cycle after the antecedent.
`define PIDDZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/piddz_pkg.sv
// Shared types, widths and register indexes of the PID controller with dead zone.
package piddz_pkg;

  localparam int GAIN_W         = 24;
  localparam int DZ_W           = 20;
  localparam int BOUND_W        = 16;
  localparam int DRV_W          = 21;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 24;
  localparam int DATA_WIDTH_DEF = 20;
  localparam int GAIN_FRAC_DEF  = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DEAD_ZONE  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_INT_BOUND  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_DRV_BOUND  = 3'd5;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [DZ_W-1:0]    dead_zone;
    logic [BOUND_W-1:0] integral_bound;
    logic [BOUND_W-1:0] drive_bound;
  } cfg_t;

  typedef struct packed {
    logic                    drive_saturated;
    logic                    in_dead_zone;
    logic signed [DRV_W-1:0] drive;
  } res_t;

endpackage

>>> rtl/piddz_cfg.sv
// Configuration register file of the PID controller with dead zone.
module piddz_cfg
  import piddz_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wen,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_GAIN_P:    cfg_r.gain_p         <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:    cfg_r.gain_i         <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:    cfg_r.gain_d         <= cfg_wdata[GAIN_W-1:0];
        REG_DEAD_ZONE: cfg_r.dead_zone      <= cfg_wdata[DZ_W-1:0];
        REG_INT_BOUND: cfg_r.integral_bound <= cfg_wdata[BOUND_W-1:0];
        REG_DRV_BOUND: cfg_r.drive_bound    <= cfg_wdata[BOUND_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/piddz_step.sv
// One controller step: error, dead zone test, gain products, clamps and next state.
module piddz_step
  import piddz_pkg::*;
#(
  parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_DEF
) (
  input  cfg_t                         cfg,
  input  logic signed [DATA_WIDTH-1:0] setpoint,
  input  logic signed [DATA_WIDTH-1:0] measured,
  input  logic signed [DATA_WIDTH:0]   prev_err,
  input  logic signed [DRV_W-1:0]      integ,
  input  logic signed [DRV_W-1:0]      held,
  output logic signed [DATA_WIDTH:0]   prev_err_nxt,
  output logic signed [DRV_W-1:0]      integ_nxt,
  output logic signed [DRV_W-1:0]      held_nxt,
  output res_t                         res
);

  localparam int E  = DATA_WIDTH + 1;
  localparam int CW = (E > DZ_W) ? E : DZ_W;
  localparam int PW = GAIN_W + E + 2;
  localparam int RW = PW - GAIN_FRAC_BITS;
  localparam int SW = ((RW > DRV_W) ? RW : DRV_W) + 2;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (GAIN_FRAC_BITS - 1);

  function automatic logic signed [RW-1:0] rnd_shift(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] y;
    y = x + HALF;
    rnd_shift = RW'(y >>> GAIN_FRAC_BITS);
  endfunction

  logic signed [E-1:0]  err;
  logic        [E-1:0]  mag;
  logic        [CW-1:0] mag_c;
  logic        [CW-1:0] dz_c;
  logic                 above;
  logic                 below;
  logic signed [E:0]    diff;
  logic signed [PW-1:0] prod_p;
  logic signed [PW-1:0] prod_i;
  logic signed [PW-1:0] prod_d;
  logic signed [RW-1:0] term_p;
  logic signed [RW-1:0] term_i;
  logic signed [RW-1:0] term_d;
  logic signed [SW-1:0] ilim;
  logic signed [SW-1:0] dlim;
  logic signed [SW-1:0] isum;
  logic signed [SW-1:0] iclamp;
  logic signed [SW-1:0] dsum;
  logic signed [SW-1:0] dclamp;
  logic                 dhit;

  assign err   = $signed({setpoint[DATA_WIDTH-1], setpoint})
               - $signed({measured[DATA_WIDTH-1], measured});
  assign mag   = err[E-1] ? E'(-err) : E'(err);
  assign mag_c = CW'(mag);
  assign dz_c  = CW'(cfg.dead_zone);
  assign above = mag_c > dz_c;
  assign below = mag_c < dz_c;

  assign diff   = $signed({err[E-1], err}) - $signed({prev_err[E-1], prev_err});
  assign prod_p = PW'($signed({1'b0, cfg.gain_p})) * PW'(err);
  assign prod_i = PW'($signed({1'b0, cfg.gain_i})) * PW'(err);
  assign prod_d = PW'($signed({1'b0, cfg.gain_d})) * PW'(diff);
  assign term_p = rnd_shift(prod_p);
  assign term_i = rnd_shift(prod_i);
  assign term_d = rnd_shift(prod_d);

  assign ilim = $signed(SW'({cfg.integral_bound, 4'b0000}));
  assign dlim = $signed(SW'({cfg.drive_bound, 4'b0000}));

  always_comb begin
    isum = SW'(integ) + SW'(term_i);
    priority if (isum > ilim) begin
      iclamp = ilim;
    end else if (isum < -ilim) begin
      iclamp = -ilim;
    end else begin
      iclamp = isum;
    end
    dsum = SW'(term_p) + iclamp + SW'(term_d);
    dhit = 1'b1;
    priority if (dsum > dlim) begin
      dclamp = dlim;
    end else if (dsum < -dlim) begin
      dclamp = -dlim;
    end else begin
      dclamp = dsum;
      dhit   = 1'b0;
    end
  end

  always_comb begin
    prev_err_nxt        = err;
    integ_nxt           = integ;
    held_nxt            = held;
    res.drive           = held;
    res.in_dead_zone    = 1'b0;
    res.drive_saturated = 1'b0;
    priority if (above) begin
      integ_nxt           = DRV_W'(iclamp);
      held_nxt            = DRV_W'(dclamp);
      res.drive           = DRV_W'(dclamp);
      res.drive_saturated = dhit;
    end else if (below) begin
      prev_err_nxt     = '0;
      held_nxt         = '0;
      res.drive        = '0;
      res.in_dead_zone = 1'b1;
    end else begin
      res.drive = held;
    end
  end

endmodule

>>> rtl/pid_deadband_clamped_top.sv
// Top level of the positional PID controller with dead zone and anti-windup.
// Pipeline: an accepted word is registered in the input stage (sp_r, ms_r), passes
// through the combinational step and is registered in the output stage (res_r, out_*).
// Throughput: one word per cycle while out_tready does not stall a full output stage;
// the step loop through the error, integral and drive registers sets that figure.
// Reset (rst_n low, synchronous) clears the configuration registers, the stored
// error, integral and drive, and empties both pipeline stages.
`include "pid_deadband_clamped_top_defines.svh"

module pid_deadband_clamped_top
  import piddz_pkg::*;
#(
  parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_DEF,
  localparam int IN_W          = ((2 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_W         = ((DRV_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0 up: setpoint, measured, zero fill.
  input  logic [IN_W-1:0]       in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // Fields from bit 0 up: drive, zero fill.
  output logic [OUT_W-1:0]      out_tdata,
  // Fields from bit 0 up: in_dead_zone, drive_saturated.
  output logic [1:0]            out_tuser,
  input  logic                  cfg_wen,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                         cfg;
  logic                         s1_v_r;
  logic signed [DATA_WIDTH-1:0] sp_r;
  logic signed [DATA_WIDTH-1:0] ms_r;
  logic                         out_v_r;
  res_t                         res_r;
  res_t                         res;
  logic signed [DATA_WIDTH:0]   prev_err_r;
  logic signed [DATA_WIDTH:0]   prev_err_nxt;
  logic signed [DRV_W-1:0]      integ_r;
  logic signed [DRV_W-1:0]      integ_nxt;
  logic signed [DRV_W-1:0]      held_r;
  logic signed [DRV_W-1:0]      held_nxt;
  logic                         adv;
  logic                         out_dz;
  logic                         out_zero;
  logic                         step_dz;
  logic                         stall_hold;

  piddz_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  piddz_step #(
    .DATA_WIDTH     (DATA_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_step (
    .cfg          (cfg),
    .setpoint     (sp_r),
    .measured     (ms_r),
    .prev_err     (prev_err_r),
    .integ        (integ_r),
    .held         (held_r),
    .prev_err_nxt (prev_err_nxt),
    .integ_nxt    (integ_nxt),
    .held_nxt     (held_nxt),
    .res          (res)
  );

  assign adv       = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      sp_r <= $signed(in_tdata[DATA_WIDTH-1:0]);
      ms_r <= $signed(in_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r    <= 1'b0;
      prev_err_r <= '0;
      integ_r    <= '0;
      held_r     <= '0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
      if (s1_v_r) begin
        prev_err_r <= prev_err_nxt;
        integ_r    <= integ_nxt;
        held_r     <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_W'($unsigned(res_r.drive));
  assign out_tuser  = {res_r.drive_saturated, res_r.in_dead_zone};

  assign out_dz     = out_v_r && res_r.in_dead_zone;
  assign out_zero   = !res_r.drive_saturated && (res_r.drive == '0);
  assign step_dz    = adv && s1_v_r && res.in_dead_zone;
  assign stall_hold = s1_v_r && out_v_r && !out_tready;

  `PIDDZ_ASSERT_SAME(a_dz_flags, out_dz, out_zero, "dead zone word with nonzero drive")
  `PIDDZ_ASSERT_NEXT(a_dz_clears_err, step_dz, prev_err_r == '0, "stored error not cleared")
  `PIDDZ_ASSERT_NEXT(a_stage_held, stall_hold, s1_v_r, "pending word lost in stall")

endmodule
